@@ hdl/pfc_pkg.sv @@
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int OBJ_W   = 32;
    localparam int IDX_W   = 6;
    localparam int DIST_W  = 18;
    localparam int LIMIT_W = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [OBJ_W-1:0]   OBJ_MAX     = 32'h7FFF_FFFF;
    localparam logic [OBJ_W-1:0]   SIGN_FLIP   = 32'h8000_0000;
    localparam logic [DIST_W-1:0]  DIST_MAX    = 18'h3FFFF;

    // input request: one point
    typedef struct packed {
        logic signed [OBJ_W-1:0] objective_one;
        logic signed [OBJ_W-1:0] objective_two;
        logic                    infeasible;
        logic                    last_point;
    } t_in_req;

    // output request: one front point
    typedef struct packed {
        logic [IDX_W-1:0]        point_index;
        logic signed [OBJ_W-1:0] out_objective_one;
        logic signed [OBJ_W-1:0] out_objective_two;
        logic [DIST_W-1:0]       crowding;
        logic                    boundary;
        logic                    last_result;
    } t_out_req;

    // stored objective pair
    typedef struct packed {
        logic signed [OBJ_W-1:0] o1;
        logic signed [OBJ_W-1:0] o2;
    } t_pt;

    // distance store entry
    typedef struct packed {
        logic              bnd;
        logic [DIST_W-1:0] acc;
    } t_dist;

    // divider handshake
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_DOM_RDI,
        ST_DOM_LDI,
        ST_DOM_RDJ,
        ST_DOM_CMP,
        ST_DOM_END,
        ST_RNK_RDA,
        ST_RNK_LDA,
        ST_RNK_RDB,
        ST_RNK_CMP,
        ST_RNK_END,
        ST_CRW_RDLO,
        ST_CRW_LDLO,
        ST_CRW_LDHI,
        ST_CRW_B0,
        ST_CRW_B0W,
        ST_CRW_B1,
        ST_CRW_B1W,
        ST_CRW_RDP,
        ST_CRW_LDP,
        ST_CRW_LDN,
        ST_CRW_LDC,
        ST_CRW_DIV,
        ST_CRW_DRD,
        ST_CRW_DWR,
        ST_EMT_RD,
        ST_EMT_RD2,
        ST_EMT_OUT,
        ST_EMT_WAIT
    } t_state;

endpackage

@@ hdl/pfc_div.sv @@
`timescale 1ns / 1ps

// Restoring divider: quotient = floor((diff << FRACTION_BITS) / range),
// with diff <= range, one quotient bit per cycle.
module pfc_div
    import pfc_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_div_ctl                 i_ctl,
    input  logic [OBJ_W-1:0]         i_diff,
    input  logic [OBJ_W-1:0]         i_range,
    output t_div_ctl                 o_ctl,
    output logic [FRACTION_BITS:0]   o_quot
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [OBJ_W:0]         r_rem, n_rem;
    logic [FRACTION_BITS:0] r_q, n_q;
    logic [OBJ_W:0]         w_cand;
    logic                   w_ge;

    // first step compares without a shift
    assign w_cand = (r_cnt == '0) ? r_rem : {r_rem[OBJ_W-1:0], 1'b0};
    assign w_ge   = w_cand >= {1'b0, i_range};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = {1'b0, i_diff};
        end else if (r_busy) begin
            n_rem = w_ge ? (w_cand - {1'b0, i_range}) : w_cand;
            n_q   = {r_q[FRACTION_BITS-1:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(FRACTION_BITS)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.done  = r_done;
    assign o_quot      = r_q;

endmodule

@@ hdl/pareto_front_crowding_top.sv @@
`timescale 1ns / 1ps

// Two-objective nondominated front with crowding distance. Points load one
// per cycle into the point memory until a request carrying last_point; the
// block then stops taking requests. The dominance scan and the joint ranking
// on both objectives make one memory read per comparison, and each interior
// front point runs the bit-serial divider once per objective. Results leave in
// ascending objective_two order, each fetched only after the previous one is
// accepted; loading resumes after the last result.
module pareto_front_crowding_top
    import pfc_pkg::*;
#(
    parameter int MAX_POINTS    = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in_req            i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output t_out_req           o_req,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int QW  = FRACTION_BITS + 1;
    localparam int SW  = ((QW > DIST_W) ? QW : DIST_W) + 1;

    typedef struct packed {
        logic [AW-1:0] idx;
        t_pt           pt;
    } t_front;

    typedef struct packed {
        logic [OBJ_W-1:0] key;
        logic [AW-1:0]    c;
    } t_sorted;

    // memories
    t_pt     pm [MAX_POINTS];
    t_front  fm [MAX_POINTS];
    t_sorted s1 [MAX_POINTS];
    t_sorted s2 [MAX_POINTS];
    t_dist   dm [MAX_POINTS];

    t_pt     r_pm_rd;
    t_front  r_fm_rd;
    t_sorted r_s1_rd, r_s2_rd;
    t_dist   r_dm_rd;

    logic [AW-1:0] pm_ra, fm_ra, s_ra, dm_ra;
    logic          pm_we, fm_we, s_we, dm_we;
    logic [AW-1:0] pm_wa, fm_wa, s1_wa, s2_wa, dm_wa;
    t_pt           pm_wd;
    t_front        fm_wd;
    t_sorted       s1_wd, s2_wd;
    t_dist         dm_wd;

    // control registers
    t_state             r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [CW-1:0]      r_n, n_n, r_i, n_i, r_j, n_j, r_k, n_k;
    logic [CW-1:0]      r_r1, n_r1, r_r2, n_r2, r_t, n_t, r_emit, n_emit;
    logic               r_beaten, n_beaten;
    logic               r_m, n_m;
    logic               r_ovalid, n_ovalid;

    // payload registers
    t_pt              r_pi, n_pi;
    logic [OBJ_W-1:0] r_lo, n_lo, r_hi, n_hi, r_prev, n_prev, r_next, n_next;
    logic [AW-1:0]    r_lo_c, n_lo_c, r_hi_c, n_hi_c, r_c, n_c;
    t_out_req         r_out, n_out;

    // divider
    t_div_ctl         div_in, div_out;
    logic [QW-1:0]    div_q;

    // helpers
    t_sorted          s_rd;
    logic [LW-1:0]    lim_eff, k_ext;
    logic [SW-1:0]    sum;
    t_pt              ld_pt;

    assign s_rd    = r_m ? r_s2_rd : r_s1_rd;
    assign lim_eff = (r_limit == '0) ? LW'(1) : LW'(r_limit);
    assign k_ext   = LW'(r_k);
    assign sum     = SW'(r_dm_rd.acc) + SW'(div_q);
    assign ld_pt.o1 = i_req.infeasible ? OBJ_MAX : i_req.objective_one;
    assign ld_pt.o2 = i_req.infeasible ? OBJ_MAX : i_req.objective_two;

    pfc_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_in),
        .i_diff  (r_next - r_prev),
        .i_range (r_hi - r_lo),
        .o_ctl   (div_out),
        .o_quot  (div_q)
    );

    // memory ports
    always_ff @(posedge i_clk) begin
        if (pm_we) pm[pm_wa] <= pm_wd;
        if (fm_we) fm[fm_wa] <= fm_wd;
        if (s_we) begin
            s1[s1_wa] <= s1_wd;
            s2[s2_wa] <= s2_wd;
        end
        if (dm_we) dm[dm_wa] <= dm_wd;
        r_pm_rd <= pm[pm_ra];
        r_fm_rd <= fm[fm_ra];
        r_s1_rd <= s1[s_ra];
        r_s2_rd <= s2[s_ra];
        r_dm_rd <= dm[dm_ra];
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_r1     = r_r1;
        n_r2     = r_r2;
        n_t      = r_t;
        n_emit   = r_emit;
        n_beaten = r_beaten;
        n_m      = r_m;
        n_ovalid = r_ovalid;
        n_pi     = r_pi;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_prev   = r_prev;
        n_next   = r_next;
        n_lo_c   = r_lo_c;
        n_hi_c   = r_hi_c;
        n_c      = r_c;
        n_out    = r_out;
        o_ready  = 1'b0;
        div_in   = '0;
        pm_ra    = '0;
        fm_ra    = '0;
        s_ra     = '0;
        dm_ra    = '0;
        pm_we    = 1'b0;
        fm_we    = 1'b0;
        s_we     = 1'b0;
        dm_we    = 1'b0;
        pm_wa    = r_n[AW-1:0];
        fm_wa    = r_k[AW-1:0];
        s1_wa    = r_r1[AW-1:0];
        s2_wa    = r_r2[AW-1:0];
        dm_wa    = r_c;
        pm_wd    = ld_pt;
        fm_wd.idx = r_i[AW-1:0];
        fm_wd.pt  = r_pi;
        s1_wd.key = r_pi.o1 ^ SIGN_FLIP;
        s1_wd.c   = r_i[AW-1:0];
        s2_wd.key = r_pi.o2 ^ SIGN_FLIP;
        s2_wd.c   = r_i[AW-1:0];
        dm_wd     = r_dm_rd;

        case (r_state)
            // load points
            ST_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (r_n < CW'(MAX_POINTS)) begin
                        pm_we = 1'b1;
                        n_n   = r_n + 1'b1;
                    end
                    if (i_req.last_point) begin
                        n_i     = '0;
                        n_k     = '0;
                        n_state = ST_DOM_RDI;
                    end
                end
            end
            // dominance scan
            ST_DOM_RDI: begin
                pm_ra   = r_i[AW-1:0];
                n_state = ST_DOM_LDI;
            end
            ST_DOM_LDI: begin
                n_pi     = r_pm_rd;
                n_j      = '0;
                n_beaten = 1'b0;
                n_state  = ST_DOM_RDJ;
            end
            ST_DOM_RDJ: begin
                pm_ra   = r_j[AW-1:0];
                n_state = ST_DOM_CMP;
            end
            ST_DOM_CMP: begin
                if (r_pm_rd.o1 < r_pi.o1 && r_pm_rd.o2 < r_pi.o2) n_beaten = 1'b1;
                n_j     = r_j + 1'b1;
                n_state = (r_j + 1'b1 == r_n) ? ST_DOM_END : ST_DOM_RDJ;
            end
            ST_DOM_END: begin
                if (!r_beaten) begin
                    fm_we = 1'b1;
                    n_k   = r_k + 1'b1;
                end
                n_i = r_i + 1'b1;
                if (r_i + 1'b1 == r_n) begin
                    n_i     = '0;
                    n_state = ST_RNK_RDA;
                end else begin
                    n_state = ST_DOM_RDI;
                end
            end
            // stable ranks on both objectives (r_i is the front slot here)
            ST_RNK_RDA: begin
                fm_ra   = r_i[AW-1:0];
                n_state = ST_RNK_LDA;
            end
            ST_RNK_LDA: begin
                n_pi    = r_fm_rd.pt;
                n_j     = '0;
                n_r1    = '0;
                n_r2    = '0;
                n_state = ST_RNK_RDB;
            end
            ST_RNK_RDB: begin
                fm_ra   = r_j[AW-1:0];
                n_state = ST_RNK_CMP;
            end
            ST_RNK_CMP: begin
                if (r_fm_rd.pt.o1 < r_pi.o1 || (r_fm_rd.pt.o1 == r_pi.o1 && r_j < r_i))
                    n_r1 = r_r1 + 1'b1;
                if (r_fm_rd.pt.o2 < r_pi.o2 || (r_fm_rd.pt.o2 == r_pi.o2 && r_j < r_i))
                    n_r2 = r_r2 + 1'b1;
                n_j     = r_j + 1'b1;
                n_state = (r_j + 1'b1 == r_k) ? ST_RNK_END : ST_RNK_RDB;
            end
            ST_RNK_END: begin
                s_we     = 1'b1;
                dm_we    = 1'b1;
                dm_wa    = r_i[AW-1:0];
                dm_wd    = '0;
                n_i      = r_i + 1'b1;
                if (r_i + 1'b1 == r_k) begin
                    n_m     = 1'b0;
                    n_state = ST_CRW_RDLO;
                end else begin
                    n_state = ST_RNK_RDA;
                end
            end
            // objective range
            ST_CRW_RDLO: begin
                s_ra    = '0;
                n_state = ST_CRW_LDLO;
            end
            ST_CRW_LDLO: begin
                n_lo    = s_rd.key;
                n_lo_c  = s_rd.c;
                s_ra    = AW'(r_k - 1'b1);
                n_state = ST_CRW_LDHI;
            end
            ST_CRW_LDHI: begin
                n_hi   = s_rd.key;
                n_hi_c = s_rd.c;
                if (s_rd.key == r_lo) begin
                    if (!r_m) begin
                        n_m     = 1'b1;
                        n_state = ST_CRW_RDLO;
                    end else begin
                        n_t     = '0;
                        n_emit  = (k_ext < lim_eff) ? r_k : CW'(lim_eff);
                        n_state = ST_EMT_RD;
                    end
                end else begin
                    n_state = ST_CRW_B0;
                end
            end
            // mark both ends as boundary points
            ST_CRW_B0: begin
                dm_ra   = r_lo_c;
                n_state = ST_CRW_B0W;
            end
            ST_CRW_B0W: begin
                dm_we      = 1'b1;
                dm_wa      = r_lo_c;
                dm_wd.bnd  = 1'b1;
                n_state    = ST_CRW_B1;
            end
            ST_CRW_B1: begin
                dm_ra   = r_hi_c;
                n_state = ST_CRW_B1W;
            end
            ST_CRW_B1W: begin
                dm_we     = 1'b1;
                dm_wa     = r_hi_c;
                dm_wd.bnd = 1'b1;
                n_t       = CW'(1);
                if (r_k > CW'(2)) begin
                    n_state = ST_CRW_RDP;
                end else if (!r_m) begin
                    n_m     = 1'b1;
                    n_state = ST_CRW_RDLO;
                end else begin
                    n_t     = '0;
                    n_emit  = (k_ext < lim_eff) ? r_k : CW'(lim_eff);
                    n_state = ST_EMT_RD;
                end
            end
            // interior point: neighbors, divide, accumulate
            ST_CRW_RDP: begin
                s_ra    = AW'(r_t - 1'b1);
                n_state = ST_CRW_LDP;
            end
            ST_CRW_LDP: begin
                n_prev  = s_rd.key;
                s_ra    = AW'(r_t + 1'b1);
                n_state = ST_CRW_LDN;
            end
            ST_CRW_LDN: begin
                n_next  = s_rd.key;
                s_ra    = r_t[AW-1:0];
                n_state = ST_CRW_LDC;
            end
            ST_CRW_LDC: begin
                n_c          = s_rd.c;
                div_in.start = 1'b1;
                n_state      = ST_CRW_DIV;
            end
            ST_CRW_DIV: begin
                if (div_out.done) n_state = ST_CRW_DRD;
            end
            ST_CRW_DRD: begin
                dm_ra   = r_c;
                n_state = ST_CRW_DWR;
            end
            ST_CRW_DWR: begin
                dm_we      = 1'b1;
                dm_wd.acc  = (sum > SW'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
                n_t        = r_t + 1'b1;
                if (r_t + CW'(2) < r_k) begin
                    n_state = ST_CRW_RDP;
                end else if (!r_m) begin
                    n_m     = 1'b1;
                    n_state = ST_CRW_RDLO;
                end else begin
                    n_t     = '0;
                    n_emit  = (k_ext < lim_eff) ? r_k : CW'(lim_eff);
                    n_state = ST_EMT_RD;
                end
            end
            // emit in objective_two order
            ST_EMT_RD: begin
                s_ra    = r_t[AW-1:0];
                n_state = ST_EMT_RD2;
            end
            ST_EMT_RD2: begin
                fm_ra   = r_s2_rd.c;
                dm_ra   = r_s2_rd.c;
                n_state = ST_EMT_OUT;
            end
            ST_EMT_OUT: begin
                n_out.point_index       = IDX_W'(r_fm_rd.idx);
                n_out.out_objective_one = r_fm_rd.pt.o1;
                n_out.out_objective_two = r_fm_rd.pt.o2;
                n_out.crowding          = r_dm_rd.bnd ? '0 : r_dm_rd.acc;
                n_out.boundary          = r_dm_rd.bnd;
                n_out.last_result       = (r_t + 1'b1 == r_emit);
                n_ovalid                = 1'b1;
                n_state                 = ST_EMT_WAIT;
            end
            ST_EMT_WAIT: begin
                if (i_ready) begin
                    n_ovalid = 1'b0;
                    n_t      = r_t + 1'b1;
                    if (r_t + 1'b1 == r_emit) begin
                        n_n     = '0;
                        n_k     = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_EMT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_limit  <= LIMIT_RESET;
            r_n      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_r1     <= '0;
            r_r2     <= '0;
            r_t      <= '0;
            r_emit   <= '0;
            r_beaten <= 1'b0;
            r_m      <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) r_limit <= i_cfg_data;
            r_n      <= n_n;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_r1     <= n_r1;
            r_r2     <= n_r2;
            r_t      <= n_t;
            r_emit   <= n_emit;
            r_beaten <= n_beaten;
            r_m      <= n_m;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pi   <= n_pi;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_prev <= n_prev;
        r_next <= n_next;
        r_lo_c <= n_lo_c;
        r_hi_c <= n_hi_c;
        r_c    <= n_c;
        r_out  <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_req   = r_out;

    // no loading while a result is pending
    a_no_load_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

    // front never exceeds the stored set
    a_front_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= r_n)
        else $error("front larger than point set");

    // boundary points carry no finite distance
    a_boundary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_req.boundary) |-> (o_req.crowding == '0))
        else $error("boundary point with nonzero crowding");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_out.done |-> (r_state == ST_CRW_DIV))
        else $error("divider done outside divide wait");

endmodule

@@ dv/pareto_front_crowding_top_tb.sv @@
`timescale 1ns / 1ps

module pareto_front_crowding_top_tb;
    import pfc_pkg::*;

    localparam int NPTS = 64;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    t_in_req            i_req = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    t_out_req           o_req;
    logic               i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_data = '0;

    pareto_front_crowding_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_req      (o_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // model state
    logic [OBJ_W-1:0]   pt_one [NPTS];
    logic [OBJ_W-1:0]   pt_two [NPTS];
    int                 pt_count;
    logic [LIMIT_W-1:0] limit_reg;

    t_in_req  point_queue [$];
    t_out_req front_queue [$];
    int       errors;
    int       sets_done;
    int       results_seen;

    function automatic logic [OBJ_W-1:0] okey(int obj, int p);
        return (obj ? pt_two[p] : pt_one[p]) ^ SIGN_FLIP;
    endfunction

    // stable insertion sort of a list by one objective
    function automatic void sort_list(int obj, int k, ref int lst[NPTS]);
        int a, b, v;
        for (a = 1; a < k; a++) begin
            v = lst[a];
            b = a;
            while (b > 0 && okey(obj, lst[b-1]) > okey(obj, v)) begin
                lst[b] = lst[b-1];
                b--;
            end
            lst[b] = v;
        end
    endfunction

    // front, crowding and ordered emission after the final point
    function automatic void predict_front();
        int front [NPTS];
        int order [NPTS];
        logic [63:0] crowd_sum [NPTS];
        bit bnd [NPTS];
        int k, i, j, m, t, lim, emit;
        bit beaten;
        logic [63:0] lo, hi, rng, diff, sum;
        t_out_req r;
        k = 0;
        for (i = 0; i < pt_count; i++) begin
            beaten = 0;
            for (j = 0; j < pt_count; j++)
                if (j != i && okey(0, i) > okey(0, j) && okey(1, i) > okey(1, j))
                    beaten = 1;
            crowd_sum[i] = 0;
            bnd[i] = 0;
            if (!beaten) begin
                front[k] = i;
                k++;
            end
        end
        for (m = 0; m < 2 && k > 0; m++) begin
            for (i = 0; i < k; i++) order[i] = front[i];
            sort_list(m, k, order);
            lo = okey(m, order[0]);
            hi = okey(m, order[k-1]);
            if (hi == lo) continue;
            bnd[order[0]] = 1;
            bnd[order[k-1]] = 1;
            rng = hi - lo;
            for (t = 1; t + 1 < k; t++) begin
                diff = okey(m, order[t+1]) - okey(m, order[t-1]);
                sum = crowd_sum[order[t]] + ((diff << 16) / rng);
                crowd_sum[order[t]] = (sum > DIST_MAX) ? DIST_MAX : sum;
            end
        end
        for (i = 0; i < k; i++) order[i] = front[i];
        sort_list(1, k, order);
        lim = (limit_reg == 0) ? 1 : limit_reg;
        emit = (k < lim) ? k : lim;
        for (t = 0; t < emit; t++) begin
            r.point_index       = order[t][IDX_W-1:0];
            r.out_objective_one = pt_one[order[t]];
            r.out_objective_two = pt_two[order[t]];
            r.crowding          = bnd[order[t]] ? '0 : crowd_sum[order[t]][DIST_W-1:0];
            r.boundary          = bnd[order[t]];
            r.last_result       = (t + 1 == emit);
            front_queue = {front_queue, r};
        end
        pt_count = 0;
    endfunction

    function automatic void accept_point(t_in_req q);
        if (pt_count < NPTS) begin
            pt_one[pt_count] = q.infeasible ? OBJ_MAX : q.objective_one;
            pt_two[pt_count] = q.infeasible ? OBJ_MAX : q.objective_two;
            pt_count++;
        end
        if (q.last_point) predict_front();
    endfunction

    // accepted-at-last-edge flags for driver and receiver
    logic o_ready_s = 1'b0;
    logic o_valid_s = 1'b0;

    // driver: one request at a time with a random gap
    int gap_in = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready_s) begin
                if (point_queue.size() > 0 && gap_in == 0) begin
                    i_req <= point_queue.pop_front();
                    gap_in <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
                end else begin
                    i_valid <= 1'b0;
                end
            end else if (!i_valid && point_queue.size() > 0) begin
                if (gap_in == 0) begin
                    i_req <= point_queue.pop_front();
                    i_valid <= 1'b1;
                    gap_in <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
                end else begin
                    gap_in <= gap_in - 1;
                end
            end
        end
    end

    // input acceptance into the model
    always @(posedge i_clk) begin
        o_ready_s <= o_ready;
        if (i_rst_n && i_valid && o_ready) accept_point(i_req);
    end

    // receiver stall
    int gap_out = 0;
    always @(negedge i_clk) begin
        if (gap_out == 0) begin
            i_ready <= 1'b1;
            if (o_valid_s) gap_out <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
        end else begin
            i_ready <= 1'b0;
            gap_out <= gap_out - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_req e;
        o_valid_s <= o_valid && i_ready;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (front_queue.size() == 0) begin
                $error("unexpected result index %0d", o_req.point_index);
                errors++;
            end else begin
                e = front_queue.pop_front();
                if (o_req.point_index !== e.point_index) begin
                    $error("point_index exp %0d got %0d", e.point_index, o_req.point_index);
                    errors++;
                end
                if (o_req.out_objective_one !== e.out_objective_one) begin
                    $error("out_objective_one exp %h got %h",
                           e.out_objective_one, o_req.out_objective_one);
                    errors++;
                end
                if (o_req.out_objective_two !== e.out_objective_two) begin
                    $error("out_objective_two exp %h got %h",
                           e.out_objective_two, o_req.out_objective_two);
                    errors++;
                end
                if (o_req.crowding !== e.crowding) begin
                    $error("crowding exp %0d got %0d", e.crowding, o_req.crowding);
                    errors++;
                end
                if (o_req.boundary !== e.boundary) begin
                    $error("boundary exp %0d got %0d", e.boundary, o_req.boundary);
                    errors++;
                end
                if (o_req.last_result !== e.last_result) begin
                    $error("last_result exp %0d got %0d", e.last_result, o_req.last_result);
                    errors++;
                end
            end
        end
    end

    // random objective, often from a narrow pool so ties and dominance occur
    function automatic logic [OBJ_W-1:0] rand_obj();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 7) << 14;
        endcase
    endfunction

    task automatic add_point(logic [31:0] a, logic [31:0] b, bit inf, bit last);
        t_in_req q;
        q.objective_one = a;
        q.objective_two = b;
        q.infeasible    = inf;
        q.last_point    = last;
        point_queue = {point_queue, q};
    endtask

    task automatic add_set(int n);
        int i;
        for (i = 0; i < n; i++)
            add_point(rand_obj(), rand_obj(), $urandom_range(0, 9) == 0, i == n - 1);
    endtask

    task automatic wait_idle();
        while (point_queue.size() > 0 || i_valid || front_queue.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = v;
    endtask

    initial begin
        int s, total;
        errors = 0;
        pt_count = 0;
        limit_reg = LIMIT_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, flat range, infeasible, single point
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        add_point(32'h0001_0000, 32'h0002_0000, 0, 0);
        add_point(32'h0002_0000, 32'h0001_0000, 0, 0);
        add_point(32'h0001_0000, 32'h0002_0000, 0, 0);
        add_point(32'hFFFF_FFFF, 32'h5555_5555, 1, 1);
        add_point(32'h0000_1234, 32'h0000_1234, 0, 1);
        add_point(32'h0000_0005, 32'h0000_0005, 0, 0);
        add_point(32'h0000_0005, 32'h0000_0005, 0, 0);
        add_point(32'h1111_1111, 32'h2222_2222, 1, 1);
        add_point(32'h0000_0000, 32'h0000_0003, 0, 0);
        add_point(32'h0000_0001, 32'h0000_0002, 0, 0);
        add_point(32'h0000_0002, 32'h0000_0001, 0, 0);
        add_point(32'h0000_0003, 32'h0000_0000, 0, 1);
        wait_idle();

        // overfull store: last point dropped but still triggers
        write_limit(7'd127);
        for (s = 0; s < 70; s++)
            add_point(s[7] ? $urandom : (s << 16), (70 - s) << 16, s == 3, s == 69);
        wait_idle();

        // random sets across limit settings, extremes included
        total = 84;
        s = 0;
        while (total < 180) begin
            case (s % 5)
                0: write_limit(7'd0);
                1: write_limit(7'd1);
                2: write_limit(7'd64);
                3: write_limit(LIMIT_W'($urandom_range(2, 10)));
                default: write_limit(7'd127);
            endcase
            begin
                int n;
                n = $urandom_range(1, 16);
                add_set(n);
                total += n;
            end
            wait_idle();
            s++;
        end
        $display("ran %0d points over %0d random sets, %0d front results checked",
                 total, s, results_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
